// File: hw/rtl/frame_pattern_trigger_core_defines.svh
// assertion macros for the frame pattern trigger checker
`ifndef FRAME_PATTERN_TRIGGER_CORE_DEFINES_SVH
`define FRAME_PATTERN_TRIGGER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame pattern trigger check failed");

// next-cycle implication, sampled on clk, off during reset
`define FPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame pattern trigger check failed");

`endif

// File: hw/rtl/fpt_pkg.sv
// shared types and constants of the frame pattern trigger
package fpt_pkg;

  localparam int unsigned FPT_MAX_PATTERN = 8;
  localparam int unsigned FPT_CFG_DW      = 64;
  localparam int unsigned FPT_CFG_IW      = 3;
  localparam int unsigned FPT_IFACE_W     = 3;
  localparam int unsigned FPT_POS_W       = 16;
  localparam int unsigned FPT_CNT_W       = 32;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_SERVICE = 2'd1,
    REQ_ARM     = 2'd2,
    REQ_DISARM  = 2'd3
  } fpt_req_t;

  typedef enum logic [FPT_CFG_IW-1:0] {
    CFG_WATCH_IFACE   = 3'd0,
    CFG_PATTERN_BYTES = 3'd1,
    CFG_PAT_LEN       = 3'd2,
    CFG_START_IDX     = 3'd3,
    CFG_AUTO_DISARM   = 3'd4,
    CFG_INJ_IFACE     = 3'd5,
    CFG_INJECT_ADDR   = 3'd6
  } fpt_cfg_idx_t;

  // frame status of the byte being processed
  typedef struct packed {
    logic frame_end;
    logic frame_hit;
  } fpt_frame_t;

endpackage

// File: hw/rtl/fpt_match.sv
// byte window, frame position and per-frame pattern hit tracking
module fpt_match import fpt_pkg::*; #(
  parameter int unsigned MAX_PATTERN = FPT_MAX_PATTERN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_step,
  input  logic [7:0]            data_byte,
  input  logic                  frame_last,
  input  logic [FPT_CFG_DW-1:0] pattern_bytes,
  input  logic [3:0]            pat_len,
  input  logic [FPT_POS_W-1:0]  start_idx,
  output fpt_frame_t            frame_o
);

  localparam int unsigned WIN_W = 8 * MAX_PATTERN;

  logic [WIN_W-1:0]       window_r;
  logic [FPT_POS_W-1:0]   pos_r;
  logic                   hit_r;

  logic [WIN_W-1:0]       window_nxt;
  logic [3:0]             eff_len;
  logic [MAX_PATTERN-1:0] lane_ok;
  logic [FPT_POS_W:0]     target;
  logic                   slide_ok;
  logic                   anchor_ok;
  logic                   byte_hit;
  logic                   hit_nxt;

  always_comb begin
    window_nxt = WIN_W'({window_r, data_byte});
    eff_len    = (pat_len > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : pat_len;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      // lanes above the pattern length are don't-care
      lane_ok[i] = (4'(i) >= eff_len) ||
                   (window_nxt[8*i +: 8] == pattern_bytes[8*i +: 8]);
    end
    slide_ok  = ({1'b0, pos_r} + 17'd1) >= 17'(eff_len);
    target    = 17'(start_idx) + 17'(eff_len) - 17'd1;
    anchor_ok = (target < 17'd65535) && (17'(pos_r) == target);
    byte_hit  = (eff_len != 4'd0) && (&lane_ok) &&
                ((start_idx == '0) ? slide_ok : anchor_ok);
    hit_nxt   = hit_r | byte_hit;
    frame_o.frame_end = frame_last;
    frame_o.frame_hit = hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      pos_r    <= '0;
      hit_r    <= 1'b0;
    end else if (byte_step) begin
      if (frame_last) begin
        window_r <= '0;
        pos_r    <= '0;
        hit_r    <= 1'b0;
      end else begin
        window_r <= window_nxt;
        hit_r    <= hit_nxt;
        // position saturates on very long frames
        if (pos_r != '1) begin
          pos_r <= pos_r + 16'd1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/fpt_trig.sv
// arm, pending and fire-count control with the result register
module fpt_trig import fpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  fpt_req_t               req,
  input  logic [FPT_IFACE_W-1:0] frame_iface,
  input  fpt_frame_t             frame_i,
  input  logic [FPT_IFACE_W-1:0] watch_iface,
  input  logic [3:0]             pat_len,
  input  logic                   auto_disarm,
  input  logic [FPT_IFACE_W-1:0] inj_iface,
  input  logic [FPT_POS_W-1:0]   inject_addr,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_fire,
  output logic [FPT_IFACE_W-1:0] out_fire_iface,
  output logic [FPT_POS_W-1:0]   out_fire_addr,
  output logic                   out_armed_now,
  output logic                   out_pending_now,
  output logic [FPT_CNT_W-1:0]   out_match_total
);

  logic                 armed_r, armed_nxt;
  logic                 pending_r, pending_nxt;
  logic [FPT_CNT_W-1:0] count_r, count_nxt;
  logic                 fire;
  logic                 out_valid_r, out_valid_nxt;

  logic                   fire_r;
  logic [FPT_IFACE_W-1:0] fire_iface_r;
  logic [FPT_POS_W-1:0]   fire_addr_r;

  always_comb begin
    armed_nxt   = armed_r;
    pending_nxt = pending_r;
    count_nxt   = count_r;
    fire        = 1'b0;
    case (req)
      REQ_BYTE: begin
        if (frame_i.frame_end && armed_r && !pending_r &&
            (frame_iface == watch_iface) && frame_i.frame_hit) begin
          pending_nxt = 1'b1;
        end
      end
      REQ_SERVICE: begin
        if (pending_r) begin
          pending_nxt = 1'b0;
          fire        = 1'b1;
          if (count_r != '1) begin
            count_nxt = count_r + 32'd1;
          end
          if (auto_disarm) begin
            armed_nxt = 1'b0;
          end
        end
      end
      REQ_ARM: begin
        if (pat_len != 4'd0) begin
          armed_nxt   = 1'b1;
          pending_nxt = 1'b0;
        end
      end
      REQ_DISARM: begin
        armed_nxt   = 1'b0;
        pending_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      pending_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        armed_r   <= armed_nxt;
        pending_r <= pending_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      fire_r       <= fire;
      fire_iface_r <= fire ? inj_iface : '0;
      fire_addr_r  <= fire ? inject_addr : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fire        = fire_r;
  assign out_fire_iface  = fire_iface_r;
  assign out_fire_addr   = fire_addr_r;
  assign out_armed_now   = armed_r;
  assign out_pending_now = pending_r;
  assign out_match_total = count_r;

endmodule

// File: hw/rtl/frame_pattern_trigger_core.sv
// top level of the frame pattern trigger
// Usage: items enter on the in_ channel (valid/ready); req_type selects a frame
// byte, a service tick, arm or disarm. Every item gives exactly one result on
// the out_ channel (valid/ready) carrying fire, the fire command fields, the
// armed and pending status after the item and the saturating fire count.
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata; the user must
// write them only while no item is in flight, as the block does not enforce
// it; indexes beyond the list are ignored. An item passes through the input
// register, then the result register. Throughput is one item per cycle while
// the receiver takes results; the pattern compare over the byte window is one
// parallel stage. When the receiver stalls, the result holds and one more item
// may sit in the input register; in_ready drops only when both registers are
// full. Reset (rst_n low, synchronous) clears the state registers to zero:
// disarmed, nothing pending, count zero, window and frame position cleared.
module frame_pattern_trigger_core import fpt_pkg::*; #(
  parameter int unsigned MAX_PATTERN = FPT_MAX_PATTERN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [FPT_CFG_IW-1:0]  cfg_index,
  input  logic [FPT_CFG_DW-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req_type,
  input  logic [7:0]             in_data_byte,
  input  logic [FPT_IFACE_W-1:0] in_frame_iface,
  input  logic                   in_frame_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_fire,
  output logic [FPT_IFACE_W-1:0] out_fire_iface,
  output logic [FPT_POS_W-1:0]   out_fire_addr,
  output logic                   out_armed_now,
  output logic                   out_pending_now,
  output logic [FPT_CNT_W-1:0]   out_match_total
);

  logic [FPT_IFACE_W-1:0] watch_iface_r;
  logic [FPT_CFG_DW-1:0]  pattern_bytes_r;
  logic [3:0]             pat_len_r;
  logic [FPT_POS_W-1:0]   start_idx_r;
  logic                   auto_disarm_r;
  logic [FPT_IFACE_W-1:0] inj_iface_r;
  logic [FPT_POS_W-1:0]   inject_addr_r;

  logic                   s1_valid_r, s1_valid_nxt;
  fpt_req_t               s1_req_r;
  logic [7:0]             s1_byte_r;
  logic [FPT_IFACE_W-1:0] s1_iface_r;
  logic                   s1_last_r;

  logic       advance;
  logic       in_xfer;
  logic       step;
  logic       byte_step;
  fpt_frame_t frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_iface_r   <= '0;
      pattern_bytes_r <= '0;
      pat_len_r       <= '0;
      start_idx_r     <= '0;
      auto_disarm_r   <= 1'b0;
      inj_iface_r     <= '0;
      inject_addr_r   <= '0;
    end else if (cfg_wr_en) begin
      case (fpt_cfg_idx_t'(cfg_index))
        CFG_WATCH_IFACE:   watch_iface_r   <= cfg_wdata[FPT_IFACE_W-1:0];
        CFG_PATTERN_BYTES: pattern_bytes_r <= cfg_wdata;
        CFG_PAT_LEN:       pat_len_r       <= cfg_wdata[3:0];
        CFG_START_IDX:     start_idx_r     <= cfg_wdata[FPT_POS_W-1:0];
        CFG_AUTO_DISARM:   auto_disarm_r   <= cfg_wdata[0];
        CFG_INJ_IFACE:     inj_iface_r     <= cfg_wdata[FPT_IFACE_W-1:0];
        CFG_INJECT_ADDR:   inject_addr_r   <= cfg_wdata[FPT_POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stage moves on whenever the result register is free or being taken
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_xfer   = in_valid && in_ready;
  assign step      = s1_valid_r && advance;
  assign byte_step = step && (s1_req_r == REQ_BYTE);

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r   <= fpt_req_t'(in_req_type);
      s1_byte_r  <= in_data_byte;
      s1_iface_r <= in_frame_iface;
      s1_last_r  <= in_frame_last;
    end
  end

  fpt_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_step     (byte_step),
    .data_byte     (s1_byte_r),
    .frame_last    (s1_last_r),
    .pattern_bytes (pattern_bytes_r),
    .pat_len       (pat_len_r),
    .start_idx     (start_idx_r),
    .frame_o       (frame)
  );

  fpt_trig u_trig (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .req             (s1_req_r),
    .frame_iface     (s1_iface_r),
    .frame_i         (frame),
    .watch_iface     (watch_iface_r),
    .pat_len         (pat_len_r),
    .auto_disarm     (auto_disarm_r),
    .inj_iface       (inj_iface_r),
    .inject_addr     (inject_addr_r),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_fire        (out_fire),
    .out_fire_iface  (out_fire_iface),
    .out_fire_addr   (out_fire_addr),
    .out_armed_now   (out_armed_now),
    .out_pending_now (out_pending_now),
    .out_match_total (out_match_total)
  );

endmodule

// File: hw/rtl/fpt_checker.sv
// port-level checks of the frame pattern trigger and their bind
`include "frame_pattern_trigger_core_defines.svh"

module fpt_checker import fpt_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_fire,
  input logic [FPT_IFACE_W-1:0] out_fire_iface,
  input logic [FPT_POS_W-1:0]   out_fire_addr,
  input logic                   out_pending_now,
  input logic [FPT_CNT_W-1:0]   out_match_total
);

  logic [FPT_CNT_W-1:0] last_total_r;
  logic                 last_pending_r;
  logic                 out_stall;
  logic                 count_ok;

  // status carried by the previous result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r   <= '0;
      last_pending_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_total_r   <= out_match_total;
      last_pending_r <= out_pending_now;
    end
  end

  assign out_stall = out_valid && !out_ready;
  // the count moves by the fire bit, or stays once saturated
  assign count_ok  = (out_match_total == last_total_r + FPT_CNT_W'(out_fire)) ||
                     ((last_total_r == '1) && (out_match_total == last_total_r));

  `FPT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_match_total) && $stable(out_fire))
  `FPT_ASSERT_IMPL(a_fire_quiet, out_valid && !out_fire, out_fire_iface == '0 && out_fire_addr == '0)
  `FPT_ASSERT_IMPL(a_count_step, out_valid, count_ok)
  `FPT_ASSERT_IMPL(a_fire_pending, out_valid && out_fire, last_pending_r && !out_pending_now)

endmodule

bind frame_pattern_trigger_core fpt_checker u_fpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_fire        (out_fire),
  .out_fire_iface  (out_fire_iface),
  .out_fire_addr   (out_fire_addr),
  .out_pending_now (out_pending_now),
  .out_match_total (out_match_total)
);
